[rtl/exact_pattern_match_finder_unit_defines.svh]
// Assertion macros for the exact pattern match finder.
// Used by the port checker; no other dependencies.
`ifndef EXACT_PATTERN_MATCH_FINDER_UNIT_DEFINES_SVH
`define EXACT_PATTERN_MATCH_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("epmf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("epmf: next-cycle check failed");

`endif

[rtl/epmf_pkg.sv]
// Shared types, constants and helpers for the exact pattern match finder.
// No dependencies.
`default_nettype none

package epmf_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int REG_WORDS = 4;
	localparam int PAT_BYTES = REG_WORDS * CFG_W / BYTE_W;
	localparam int IDX_W     = 7;
	localparam int ORD_W     = 32;
	localparam int MOFF_W    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_WORD_0 = 3'd1,
		REG_PATTERN_WORD_1 = 3'd2,
		REG_PATTERN_WORD_2 = 3'd3,
		REG_PATTERN_WORD_3 = 3'd4
	} cfg_reg_e;

	typedef logic [REG_WORDS-1:0][CFG_W-1:0] pat_words_t;

	// Pattern control handed from the register block to the scanner.
	typedef struct packed {
		logic             len_ok;
		logic [LEN_W-1:0] len_m1;
	} cfg_ctl_t;

	// Byte i of the pattern registers; bytes past the registers read as zero.
	function automatic logic [BYTE_W-1:0] pattern_byte(pat_words_t words, logic [IDX_W-1:0] i);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (i < IDX_W'(PAT_BYTES)) begin
			b = words[i[4:3]][{i[2:0], 3'b000} +: BYTE_W];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/epmf_if.sv]
// Valid/ready channel interfaces for text beats and match beats.
// Depends on epmf_pkg for field widths.
`default_nettype none

interface epmf_text_if;
	logic                        valid;
	logic                        ready;
	logic [epmf_pkg::BYTE_W-1:0] text_byte;
	logic                        text_start;

	modport source (output valid, output text_byte, output text_start, input ready);
	modport sink (input valid, input text_byte, input text_start, output ready);
endinterface

interface epmf_match_if;
	logic                        valid;
	logic                        ready;
	logic [epmf_pkg::MOFF_W-1:0] match_offset;
	logic [epmf_pkg::ORD_W-1:0]  match_ordinal;
	logic                        offset_overflow;

	modport source (output valid, output match_offset, output match_ordinal,
		output offset_overflow, input ready);
	modport sink (input valid, input match_offset, input match_ordinal,
		input offset_overflow, output ready);
endinterface

`default_nettype wire

[rtl/epmf_cfg_align.sv]
// Pattern registers plus a registered, length-aligned copy of the pattern.
// Depends on epmf_pkg.
`default_nettype none

module epmf_cfg_align #(
	parameter int MAX_PATTERN = epmf_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         cfg_we,
	input  wire logic [epmf_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  wire logic [epmf_pkg::CFG_W-1:0]                   cfg_data,
	output epmf_pkg::cfg_ctl_t                                ctl,
	output logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0]      pat,
	output logic [MAX_PATTERN-1:0]                            use_mask
);

	logic [epmf_pkg::LEN_W-1:0]                      len_q;
	epmf_pkg::pat_words_t                            words_q;
	epmf_pkg::cfg_ctl_t                              ctl_q;
	logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0]    pat_q;
	logic [MAX_PATTERN-1:0]                          mask_q;

	epmf_pkg::cfg_ctl_t                              ctl_d;
	logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0]    pat_d;
	logic [MAX_PATTERN-1:0]                          mask_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			words_q <= '0;
		end else if (cfg_we) begin
			unique case (epmf_pkg::cfg_reg_e'(cfg_index))
				epmf_pkg::REG_PATTERN_LENGTH: len_q <= cfg_data[epmf_pkg::LEN_W-1:0];
				epmf_pkg::REG_PATTERN_WORD_0: words_q[0] <= cfg_data;
				epmf_pkg::REG_PATTERN_WORD_1: words_q[1] <= cfg_data;
				epmf_pkg::REG_PATTERN_WORD_2: words_q[2] <= cfg_data;
				epmf_pkg::REG_PATTERN_WORD_3: words_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Slot m holds the pattern byte that must sit m bytes back from the newest one.
	always_comb begin
		logic [epmf_pkg::IDX_W-1:0] idx;
		idx    = '0;
		pat_d  = '0;
		mask_d = '0;
		for (int m = 0; m < MAX_PATTERN; m++) begin
			mask_d[m] = epmf_pkg::IDX_W'(m) < epmf_pkg::IDX_W'(len_q);
			idx       = epmf_pkg::IDX_W'(len_q) - epmf_pkg::IDX_W'(1) - epmf_pkg::IDX_W'(m);
			if (mask_d[m]) begin
				pat_d[m] = epmf_pkg::pattern_byte(words_q, idx);
			end
		end
		ctl_d.len_ok = (len_q != '0) &&
			(epmf_pkg::IDX_W'(len_q) <= epmf_pkg::IDX_W'(MAX_PATTERN));
		ctl_d.len_m1 = len_q - epmf_pkg::LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		pat_q  <= pat_d;
		mask_q <= mask_d;
	end

	assign ctl      = ctl_q;
	assign pat      = pat_q;
	assign use_mask = mask_q;

endmodule

`default_nettype wire

[rtl/epmf_scan_core.sv]
// Input register, window/offset/ordinal state, parallel compare and result register.
// Depends on epmf_pkg and the channel interfaces in epmf_if.sv.
`default_nettype none

module epmf_scan_core #(
	parameter int MAX_PATTERN = epmf_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = epmf_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	epmf_text_if.sink                                     text,
	epmf_match_if.source                                  match,
	input  wire epmf_pkg::cfg_ctl_t                       ctl,
	input  wire logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0] pat,
	input  wire logic [MAX_PATTERN-1:0]                   use_mask
);

	localparam int WIN    = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int SEEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int OFF_EXT = (OFFSET_BITS > epmf_pkg::MOFF_W) ? OFFSET_BITS : epmf_pkg::MOFF_W;
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN - 1);

	// input stage
	logic                        valid_s1;
	logic [epmf_pkg::BYTE_W-1:0] byte_s1;
	logic                        start_s1;

	// per-text state
	logic [epmf_pkg::BYTE_W-1:0] window_q [WIN];
	logic [SEEN_W-1:0]           seen_q;
	logic [OFFSET_BITS-1:0]      pos_q;
	logic [epmf_pkg::ORD_W-1:0]  total_q;
	logic                        sat_q;

	// result register
	logic                        out_valid_q;
	logic [epmf_pkg::MOFF_W-1:0] off_q;
	logic [epmf_pkg::ORD_W-1:0]  ord_q;
	logic                        ovf_q;

	logic [SEEN_W-1:0]           seen_eff;
	logic [OFFSET_BITS-1:0]      pos_eff;
	logic [epmf_pkg::ORD_W-1:0]  total_eff;
	logic                        sat_eff;
	logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0] seq;
	logic [MAX_PATTERN-1:0]      byte_ok;
	logic                        hit;
	logic                        out_free;
	logic                        advance;
	logic [OFFSET_BITS-1:0]      back;
	logic [OFFSET_BITS-1:0]      off_full;
	logic [OFF_EXT-1:0]          off_wide;

	// A start beat sees cleared history.
	assign seen_eff  = start_s1 ? '0 : seen_q;
	assign pos_eff   = start_s1 ? '0 : pos_q;
	assign total_eff = start_s1 ? '0 : total_q;
	assign sat_eff   = start_s1 ? 1'b0 : sat_q;

	always_comb begin
		seq    = '0;
		seq[0] = byte_s1;
		for (int m = 1; m < MAX_PATTERN; m++) begin
			seq[m] = window_q[m-1];
		end
		for (int m = 0; m < MAX_PATTERN; m++) begin
			byte_ok[m] = !use_mask[m] || (seq[m] == pat[m]);
		end
	end

	assign hit = valid_s1 && ctl.len_ok &&
		(epmf_pkg::LEN_W'(seen_eff) >= ctl.len_m1) && (&byte_ok);

	assign back     = OFFSET_BITS'(ctl.len_m1);
	assign off_full = (pos_eff >= back) ? pos_eff - back : '0;
	assign off_wide = OFF_EXT'(off_full);

	assign out_free   = !out_valid_q || match.ready;
	assign advance    = valid_s1 && (!hit || out_free);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1  <= text.text_byte;
			start_s1 <= text.text_start;
		end
	end

	// Entries beyond the fill count are never compared, so the window needs no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			window_q[0] <= byte_s1;
			for (int k = 1; k < WIN; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			pos_q   <= '0;
			total_q <= '0;
			sat_q   <= 1'b0;
		end else if (advance) begin
			seen_q <= (seen_eff < SEEN_MAX) ? seen_eff + SEEN_W'(1) : seen_eff;
			if (pos_eff == {OFFSET_BITS{1'b1}}) begin
				pos_q <= pos_eff;
				sat_q <= 1'b1;
			end else begin
				pos_q <= pos_eff + OFFSET_BITS'(1);
				sat_q <= sat_eff;
			end
			if (hit && (total_eff != {epmf_pkg::ORD_W{1'b1}})) begin
				total_q <= total_eff + epmf_pkg::ORD_W'(1);
			end else begin
				total_q <= total_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (match.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			off_q <= off_wide[epmf_pkg::MOFF_W-1:0];
			ord_q <= total_eff;
			ovf_q <= sat_eff;
		end
	end

	assign match.valid           = out_valid_q;
	assign match.match_offset    = off_q;
	assign match.match_ordinal   = ord_q;
	assign match.offset_overflow = ovf_q;

endmodule

`default_nettype wire

[rtl/exact_pattern_match_finder_unit.sv]
// Exact pattern match finder: streams text one byte per beat and reports every
// occurrence (overlaps included) of a configured byte pattern of up to MAX_PATTERN
// bytes. Throughput is one text beat per clock while the text channel is not stalled:
// the state loop that updates window, fill count, offset and ordinal sets the rate.
// A result reaches the match channel from the text beat that completes the match
// via the input register, then the result register. The result register decouples the
// sides: text beats keep flowing while a result waits, and the text channel only stalls
// when a new match is ready and the previous result has not been taken. text.ready
// depends combinationally on match.ready. Pattern registers may only be written while
// the block is idle; they are copied into a length-aligned form the cycle after a write.
// A pattern length of 0 or above MAX_PATTERN never matches. text_start clears history.
// Depends on epmf_pkg, epmf_if.sv, epmf_cfg_align and epmf_scan_core.
`default_nettype none

module exact_pattern_match_finder_unit #(
	parameter int MAX_PATTERN = epmf_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = epmf_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [epmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [epmf_pkg::CFG_W-1:0]     cfg_data,
	// channels
	epmf_text_if.sink                           text,
	epmf_match_if.source                        match
);

	epmf_pkg::cfg_ctl_t                           ctl;
	logic [MAX_PATTERN-1:0][epmf_pkg::BYTE_W-1:0] pat;
	logic [MAX_PATTERN-1:0]                       use_mask;

	// Register block: pattern bytes reordered so slot m lines up with the byte m back.
	epmf_cfg_align #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.pat      (pat),
		.use_mask (use_mask)
	);

	// Scanner: compares the whole aligned pattern against window plus current byte.
	epmf_scan_core #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.match   (match),
		.ctl     (ctl),
		.pat     (pat),
		.use_mask(use_mask)
	);

endmodule

`default_nettype wire

[rtl/epmf_checker.sv]
// Port-level assertions for the exact pattern match finder, bound to the top level.
// Depends on epmf_pkg and exact_pattern_match_finder_unit_defines.svh.
`default_nettype none
`include "exact_pattern_match_finder_unit_defines.svh"

module epmf_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           text_valid,
	input wire logic                           text_ready,
	input wire logic                           match_valid,
	input wire logic                           match_ready,
	input wire logic [epmf_pkg::MOFF_W-1:0]    match_offset,
	input wire logic [epmf_pkg::ORD_W-1:0]     match_ordinal,
	input wire logic                           offset_overflow
);

	logic                                         text_beat;
	logic                                         out_stalled;
	logic [epmf_pkg::MOFF_W+epmf_pkg::ORD_W:0]    result_bus;

	assign text_beat   = text_valid && text_ready;
	assign out_stalled = match_valid && !match_ready;
	assign result_bus  = {match_offset, match_ordinal, offset_overflow};

	// Text side never stalls while the result register is free.
	`EPMF_ASSERT_IMPL(a_ready_when_free, clk, arst_n, !match_valid || match_ready, text_ready)

	// A fresh result comes from a text beat accepted earlier, via the input register.
	`EPMF_ASSERT_IMPL(a_result_latency, clk, arst_n, $rose(match_valid), $past(text_beat, 2))

	// A waiting result holds.
	`EPMF_ASSERT_NEXT(a_result_hold, clk, arst_n, out_stalled, match_valid && $stable(result_bus))

endmodule

bind exact_pattern_match_finder_unit epmf_checker u_epmf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.match_valid    (match.valid),
	.match_ready    (match.ready),
	.match_offset   (match.match_offset),
	.match_ordinal  (match.match_ordinal),
	.offset_overflow(match.offset_overflow)
);

`default_nettype wire
